/* rtl/lfu_pkg.sv */
// shared types and constants for the lfu cache
`timescale 1ns / 1ps

package lfu_pkg;

    localparam int KEY_W   = 32;
    localparam int DATA_W  = 32;
    localparam int USES_W  = 16;
    localparam int STAMP_W = 48;
    localparam int CAP_W   = 5;

    localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
    localparam logic [USES_W-1:0] USES_MAX   = 16'hFFFF;
    localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

    // operation codes of a request
    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    typedef struct packed {
        logic                     mode;
        logic signed [KEY_W-1:0]  key;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] read_value;
        logic                     evicted;
        logic signed [KEY_W-1:0]  evicted_key;
    } rsp_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [DATA_W-1:0]  data;
        logic [USES_W-1:0]  uses;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_UPDATE
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic rd_en;
        logic update;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic last_rd;
    } dp_sts_t;

endpackage

/* rtl/lfu_cache_replacement.sv */
// lfu cache: one request per scan of all entries, one response per request
// a new request is taken only in idle, once the previous scan, compare drain and update
//   have run; the update waits while an older response is still held. The entry memory
//   scan reads one entry per cycle
// reset: all entries invalid, occupancy and stamp zero, capacity register 16
`timescale 1ns / 1ps

module lfu_cache_replacement
    import lfu_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata,
    input  logic             req_valid,
    output logic             req_ready,
    input  req_t             req,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output rsp_t             rsp
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    // control sequencer
    lfu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // storage and compare datapath
    lfu_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp       (rsp)
    );

endmodule

/* rtl/lfu_ctrl.sv */
// sequencing state machine for the lfu cache
`timescale 1ns / 1ps

module lfu_ctrl
    import lfu_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    output logic    req_ready,
    output logic    rsp_valid,
    input  logic    rsp_ready,
    output dp_cmd_t cmd,
    input  dp_sts_t sts
);

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (sts.last_rd)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
                state_next = ST_UPDATE;
            ST_UPDATE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs and commands
    always_comb
    begin
        req_ready   = (state_reg == ST_IDLE);
        cmd.capture = (state_reg == ST_IDLE) && req_valid;
        cmd.rd_en   = (state_reg == ST_SCAN);
        cmd.update  = (state_reg == ST_UPDATE) && (!rsp_valid_reg || rsp_ready);
    end

    // response valid flag
    always_comb
    begin
        priority if (cmd.update)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    assign rsp_valid = rsp_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // a response only appears after an update step
    a_rsp_from_update: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg) == ST_UPDATE)
        else $error("response raised outside update");

    // an update always returns to idle
    a_update_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |=> state_reg == ST_IDLE)
        else $error("update did not return to idle");

    // a waiting response stays valid until taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_ready) |=> rsp_valid_reg)
        else $error("response dropped before accept");

endmodule

/* rtl/lfu_datapath.sv */
// entry storage, scan compare and update logic for the lfu cache
`timescale 1ns / 1ps

module lfu_datapath
    import lfu_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata,
    input  req_t             req,
    input  dp_cmd_t          cmd,
    output dp_sts_t          sts,
    output rsp_t             rsp
);

    localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int OCC_W    = $clog2(CAPACITY + 1);
    localparam int CW       = (OCC_W > CAP_W) ? OCC_W : CAP_W;
    localparam int CapLimit = (CAPACITY < 31) ? CAPACITY : 31;

    // entry memory and per-entry valid bits
    entry_t mem [CAPACITY];
    entry_t rd_data_reg;

    logic [CAPACITY-1:0] valid_reg;
    logic [CAPACITY-1:0] valid_next;
    logic [OCC_W-1:0]    occ_reg;
    logic [STAMP_W-1:0]  stamp_reg;
    logic [CAP_W-1:0]    capacity_reg;
    req_t                req_reg;
    rsp_t                rsp_reg;

    // scan address and compare stage
    logic [AW-1:0] rd_addr_reg;
    logic [AW-1:0] cmp_idx_reg;
    logic          cmp_en_reg;

    // scan results
    logic               found_match_reg;
    logic [AW-1:0]      match_idx_reg;
    logic [DATA_W-1:0]  match_data_reg;
    logic [USES_W-1:0]  match_uses_reg;
    logic               have_free_reg;
    logic [AW-1:0]      free_idx_reg;
    logic               have_victim_reg;
    logic [AW-1:0]      vic_idx_reg;
    logic [KEY_W-1:0]   vic_key_reg;
    logic [USES_W-1:0]  vic_uses_reg;
    logic [STAMP_W-1:0] vic_stamp_reg;

    logic cur_valid;
    logic key_eq;
    logic cand_less;

    logic [CAP_W-1:0]  cap_eff;
    logic              occ_full;
    logic              hit;
    logic              do_insert;
    logic              do_evict;
    logic              ins_ok;
    logic [AW-1:0]     ins_slot;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    entry_t            wr_entry;
    logic [USES_W-1:0] uses_inc;
    rsp_t              rsp_next;

    assign sts.last_rd = (rd_addr_reg == AW'(CAPACITY - 1));
    assign rsp         = rsp_reg;

    // capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            capacity_reg <= CAP_RESET;
        else if (cfg_we)
            capacity_reg <= cfg_wdata;
    end

    // memory read port
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
            rd_data_reg <= mem[rd_addr_reg];
    end

    // memory write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_entry;
    end

    // compare of the entry read in the previous cycle
    always_comb
    begin
        cur_valid = valid_reg[cmp_idx_reg];
        key_eq    = (rd_data_reg.key == req_reg.key);
        cand_less = {rd_data_reg.uses, rd_data_reg.stamp} < {vic_uses_reg, vic_stamp_reg};
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            req_reg <= req;
    end

    // scan sequencing and flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_addr_reg     <= '0;
            cmp_idx_reg     <= '0;
            cmp_en_reg      <= 1'b0;
            found_match_reg <= 1'b0;
            have_free_reg   <= 1'b0;
            have_victim_reg <= 1'b0;
        end
        else
        begin
            cmp_en_reg  <= cmd.rd_en;
            cmp_idx_reg <= rd_addr_reg;
            if (cmd.capture)
            begin
                rd_addr_reg     <= '0;
                found_match_reg <= 1'b0;
                have_free_reg   <= 1'b0;
                have_victim_reg <= 1'b0;
            end
            else
            begin
                if (cmd.rd_en)
                    rd_addr_reg <= rd_addr_reg + AW'(1);
                if (cmp_en_reg)
                begin
                    if (cur_valid && key_eq)
                        found_match_reg <= 1'b1;
                    if (!cur_valid)
                        have_free_reg <= 1'b1;
                    if (cur_valid)
                        have_victim_reg <= 1'b1;
                end
            end
        end
    end

    // scan payload captures
    always_ff @(posedge clk)
    begin
        if (cmp_en_reg)
        begin
            if (cur_valid && key_eq && !found_match_reg)
            begin
                match_idx_reg  <= cmp_idx_reg;
                match_data_reg <= rd_data_reg.data;
                match_uses_reg <= rd_data_reg.uses;
            end
            if (!cur_valid && !have_free_reg)
                free_idx_reg <= cmp_idx_reg;
            if (cur_valid && (!have_victim_reg || cand_less))
            begin
                vic_idx_reg   <= cmp_idx_reg;
                vic_key_reg   <= rd_data_reg.key;
                vic_uses_reg  <= rd_data_reg.uses;
                vic_stamp_reg <= rd_data_reg.stamp;
            end
        end
    end

    // replacement decision
    always_comb
    begin
        cap_eff   = (capacity_reg > CAP_W'(CapLimit)) ? CAP_W'(CapLimit) : capacity_reg;
        occ_full  = CW'(occ_reg) >= CW'(cap_eff);
        hit       = found_match_reg;
        do_insert = (req_reg.mode == MODE_PUT) && !hit && (cap_eff != '0);
        do_evict  = do_insert && occ_full && have_victim_reg;
        ins_ok    = do_evict || have_free_reg;
        if (do_evict && !(have_free_reg && (free_idx_reg < vic_idx_reg)))
            ins_slot = vic_idx_reg;
        else
            ins_slot = free_idx_reg;
        uses_inc  = (match_uses_reg == USES_MAX) ? USES_MAX : match_uses_reg + USES_W'(1);

        wr_en   = cmd.update && (hit || (do_insert && ins_ok));
        wr_addr = hit ? match_idx_reg : ins_slot;
        if (hit)
        begin
            wr_entry.key   = req_reg.key;
            wr_entry.data  = (req_reg.mode == MODE_PUT) ? req_reg.value : match_data_reg;
            wr_entry.uses  = uses_inc;
            wr_entry.stamp = stamp_reg;
        end
        else
        begin
            wr_entry.key   = req_reg.key;
            wr_entry.data  = req_reg.value;
            wr_entry.uses  = USES_W'(1);
            wr_entry.stamp = stamp_reg;
        end

        rsp_next.hit         = hit;
        rsp_next.read_value  = (hit && (req_reg.mode == MODE_GET)) ? match_data_reg : MISS_VALUE;
        rsp_next.evicted     = do_evict;
        rsp_next.evicted_key = do_evict ? vic_key_reg : '0;
    end

    // next valid bits: victim cleared, insert slot set
    always_comb
    begin
        valid_next = valid_reg;
        if (!hit && do_insert && ins_ok)
        begin
            if (do_evict)
                valid_next[vic_idx_reg] = 1'b0;
            valid_next[ins_slot] = 1'b1;
        end
    end

    // valid bits, occupancy and stamp counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            occ_reg   <= '0;
            stamp_reg <= '0;
        end
        else if (cmd.update)
        begin
            if (wr_en)
                stamp_reg <= stamp_reg + STAMP_W'(1);
            valid_reg <= valid_next;
            if (!hit && do_insert && ins_ok && !do_evict)
                occ_reg <= occ_reg + OCC_W'(1);
        end
    end

    // response register
    always_ff @(posedge clk)
    begin
        if (cmd.update)
            rsp_reg <= rsp_next;
    end

    // occupancy tracks the valid bits
    a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
        32'(occ_reg) == $countones(valid_reg))
        else $error("occupancy out of step with valid bits");

    // a hit always advances the stamp counter by one
    a_hit_stamp: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.update && found_match_reg) |=> stamp_reg == STAMP_W'($past(stamp_reg) + 1))
        else $error("stamp not advanced on hit");

    // an eviction only picks a valid victim
    a_evict_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.update && do_evict) |-> valid_reg[vic_idx_reg])
        else $error("eviction of an invalid entry");

endmodule

/* test/lfu_cache_replacement_checker.sv */
// checker for the lfu cache: predicts every response and compares it field by field
`timescale 1ns / 1ps

module lfu_cache_replacement_checker
    import lfu_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata,
    input  logic             req_valid,
    input  logic             req_ready,
    input  req_t             req,
    input  logic             rsp_valid,
    input  logic             rsp_ready,
    input  rsp_t             rsp,
    output int               mismatches,
    output int               outstanding,
    output int               hits_seen,
    output int               evictions_seen
);

    // predicted cache contents
    logic [CAP_W-1:0]   cap_reg;
    logic               slot_valid [CAPACITY];
    entry_t             slot [CAPACITY];
    logic [STAMP_W-1:0] stamp_now;
    int                 fill;

    // responses owed by the block, oldest first
    rsp_t               owed_rsp [$];
    int                 rsp_index;

    task automatic report_mismatch(input string field, input logic [31:0] seen,
                                   input logic [31:0] want);
        mismatches++;
        $display("mismatch on %s at response %0d: got %h, expected %h",
                 field, rsp_index, seen, want);
    endtask

    // count a use, saturating, and move the entry to the newest stamp
    function automatic void raise_use(int s);
        if (slot[s].uses != USES_MAX)
            slot[s].uses = slot[s].uses + 1'b1;
        slot[s].stamp = stamp_now;
        stamp_now = stamp_now + 1'b1;
    endfunction

    // apply one request to the predicted contents and return its response
    function automatic rsp_t lookup_and_update(req_t r);
        rsp_t a;
        int   found;
        int   victim;
        int   limit;
        int   i;
        found = -1;
        victim = -1;
        limit = (cap_reg > CAPACITY) ? CAPACITY : int'(cap_reg);
        a.hit = 1'b0;
        a.read_value = MISS_VALUE;
        a.evicted = 1'b0;
        a.evicted_key = '0;

        // key match, lowest slot first
        for (i = 0; i < CAPACITY; i++)
            if (found < 0 && slot_valid[i] && slot[i].key == r.key)
                found = i;

        if (found >= 0)
        begin
            a.hit = 1'b1;
            if (r.mode == MODE_GET)
                a.read_value = slot[found].data;
            else
                slot[found].data = r.value;
            raise_use(found);
            return a;
        end
        if (r.mode == MODE_GET || limit == 0)
            return a;

        // full: drop the least used entry, oldest stamp on a tie
        if (fill >= limit)
        begin
            for (i = 0; i < CAPACITY; i++)
                if (slot_valid[i] && (victim < 0 || slot[i].uses < slot[victim].uses ||
                    (slot[i].uses == slot[victim].uses &&
                     slot[i].stamp < slot[victim].stamp)))
                    victim = i;
            if (victim >= 0)
            begin
                slot_valid[victim] = 1'b0;
                if (fill > 0)
                    fill--;
                a.evicted = 1'b1;
                a.evicted_key = slot[victim].key;
            end
        end

        // insert into the lowest free slot
        for (i = 0; i < CAPACITY; i++)
            if (!slot_valid[i] && found < 0)
            begin
                found = i;
                slot_valid[i] = 1'b1;
                slot[i].key = r.key;
                slot[i].data = r.value;
                slot[i].uses = USES_W'(1);
                slot[i].stamp = stamp_now;
                stamp_now = stamp_now + 1'b1;
                fill++;
            end
        return a;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            cap_reg = CAP_RESET;
            for (int i = 0; i < CAPACITY; i++)
                slot_valid[i] = 1'b0;
            stamp_now = '0;
            fill = 0;
            owed_rsp.delete();
            rsp_index = 0;
            outstanding = 0;
            mismatches = 0;
            hits_seen = 0;
            evictions_seen = 0;
        end
        else
        begin
            // capacity register write
            if (cfg_we)
                cap_reg = cfg_wdata;

            // response side
            if (rsp_valid && rsp_ready)
            begin
                if (owed_rsp.size() == 0)
                    report_mismatch("response with no request outstanding",
                                    rsp.read_value, '0);
                else
                begin
                    want = owed_rsp.pop_front();
                    if (rsp.hit !== want.hit)
                        report_mismatch("hit", 32'(rsp.hit), 32'(want.hit));
                    if (rsp.read_value !== want.read_value)
                        report_mismatch("read_value", rsp.read_value, want.read_value);
                    if (rsp.evicted !== want.evicted)
                        report_mismatch("evicted", 32'(rsp.evicted), 32'(want.evicted));
                    if (rsp.evicted_key !== want.evicted_key)
                        report_mismatch("evicted_key", rsp.evicted_key, want.evicted_key);
                    hits_seen += int'(want.hit);
                    evictions_seen += int'(want.evicted);
                end
                rsp_index++;
            end

            // request side
            if (req_valid && req_ready)
                owed_rsp.push_back(lookup_and_update(req));
            outstanding = owed_rsp.size();
        end
    end

endmodule

/* test/lfu_cache_replacement_test.sv */
// testbench top for the lfu cache: stimulus, back-pressure, watchdog and verdict
`timescale 1ns / 1ps

module lfu_cache_replacement_test
    import lfu_pkg::*;
();

    localparam int CAPACITY    = 16;
    localparam int POOL_SIZE   = 24;
    localparam int SEGMENTS    = 6;
    localparam int SEG_ITEMS   = 75;
    localparam int STALL_LIMIT = 2000;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic [CAP_W-1:0] cfg_wdata = '0;
    logic             req_valid = 1'b0;
    logic             req_ready;
    req_t             req = '0;
    logic             rsp_valid;
    logic             rsp_ready = 1'b0;
    rsp_t             rsp;

    int               mismatches;
    int               outstanding;
    int               hits_seen;
    int               evictions_seen;
    int               send_idle_pct = 37;
    int               recv_idle_pct = 83;
    int               requests_sent = 0;
    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    int               seg_cap [SEGMENTS] = '{31, 3, 16, 1, 0, 9};

    lfu_cache_replacement #(.CAPACITY(CAPACITY)) DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    lfu_cache_replacement_checker #(.CAPACITY(CAPACITY)) lfu_check
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req            (req),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .rsp            (rsp),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .hits_seen      (hits_seen),
        .evictions_seen (evictions_seen)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // response back-pressure, redrawn every cycle
    always @(negedge clk)
        rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

    function automatic req_t make_request(logic mode, logic [31:0] key, logic [31:0] value);
        req_t r;
        r.mode = mode;
        r.key = key;
        r.value = value;
        return r;
    endfunction

    // offer one request after a random gap and hold it until accepted
    task automatic push_request(input req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        requests_sent++;
        @(negedge clk);
    endtask

    // capacity write once the block has drained and is idle
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        req_valid <= 1'b0;
        while (outstanding != 0 || !req_ready)
            @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= cap;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // watchdog on cycles with no accepted request or response
    initial
    begin
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
                stall = 0;
            else
                stall++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        req_t r;
        int   i;
        int   s;
        int   n;
        int   eff;
        int   span;

        // key pool: field extremes first, random keys after
        key_pool[0] = 32'h7FFF_FFFF;
        key_pool[1] = 32'h8000_0000;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        for (i = 4; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty miss, extreme keys and values, hits and update
        push_request(make_request(MODE_GET, 32'h0000_0000, 32'h0000_0000));
        push_request(make_request(MODE_PUT, 32'h7FFF_FFFF, 32'h8000_0000));
        push_request(make_request(MODE_PUT, 32'h8000_0000, 32'h7FFF_FFFF));
        push_request(make_request(MODE_PUT, 32'h0000_0000, 32'h0000_0000));
        push_request(make_request(MODE_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        push_request(make_request(MODE_GET, 32'h7FFF_FFFF, 32'h0000_0000));
        push_request(make_request(MODE_GET, 32'h8000_0000, 32'hFFFF_FFFF));
        push_request(make_request(MODE_PUT, 32'h0000_0000, 32'h1234_5678));
        push_request(make_request(MODE_GET, 32'h0000_0000, 32'h0000_0000));

        // capacity lowered below occupancy: each put miss evicts one and inserts
        write_capacity(5'd2);
        push_request(make_request(MODE_PUT, 32'h0000_1111, 32'h5555_AAAA));
        push_request(make_request(MODE_PUT, 32'h2222_0000, 32'hAAAA_5555));
        push_request(make_request(MODE_GET, 32'h2222_0000, 32'h0000_0000));
        push_request(make_request(MODE_PUT, 32'h7FFF_FFFF, 32'h0000_0000));

        // zero capacity: put misses are dropped, hits still update
        write_capacity(5'd0);
        push_request(make_request(MODE_PUT, 32'h3333_3333, 32'h0F0F_0F0F));
        push_request(make_request(MODE_GET, 32'h3333_3333, 32'h0000_0000));
        push_request(make_request(MODE_PUT, 32'h0000_0000, 32'hDEAD_BEEF));
        push_request(make_request(MODE_GET, 32'h0000_0000, 32'h0000_0000));

        // capacity above the slot count acts as full size
        write_capacity(5'd31);
        for (i = 0; i < 8; i++)
            push_request(make_request(MODE_PUT, 32'h4000_0000 + i, ~i));

        // random segments, each with its own capacity; the back-pressure profile changes at segments 2 and 4
        for (s = 0; s < SEGMENTS; s++)
        begin
            if (s == 2)
            begin
                send_idle_pct = 83;
                recv_idle_pct = 37;
            end
            else if (s == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_capacity(CAP_W'(seg_cap[s]));
            eff = (seg_cap[s] > CAPACITY) ? CAPACITY : seg_cap[s];
            span = (eff + 6 > POOL_SIZE) ? POOL_SIZE : eff + 6;
            for (n = 0; n < SEG_ITEMS; n++)
            begin
                r.mode = ($urandom_range(99) < 50) ? MODE_PUT : MODE_GET;
                r.key = ($urandom_range(7) == 0) ? $urandom : key_pool[$urandom_range(span - 1)];
                r.value = $urandom;
                push_request(r);
            end
        end

        // drain, then give the block time to show any extra response
        req_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (CAPACITY + 3) @(negedge clk);

        $display("covered %0d requests at capacities 0 through 31 under three stall profiles",
                 requests_sent);
        $display("responses checked included %0d hits and %0d evictions",
                 hits_seen, evictions_seen);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* lfu_cache_replacement.f */
rtl/lfu_pkg.sv
rtl/lfu_ctrl.sv
rtl/lfu_datapath.sv
rtl/lfu_cache_replacement.sv
test/lfu_cache_replacement_checker.sv
test/lfu_cache_replacement_test.sv
